// ===== sv/fmbs_pkg.sv =====
package fmbs_pkg;

  // table sizes and hit cap
  localparam int MAX_REF  = 65536;
  localparam int MAX_HITS = 32;

  localparam int DATA_W   = 16;
  localparam int REF_AW   = $clog2(MAX_REF);
  localparam int OCC_AW   = REF_AW + 2;
  localparam int OCC_DEPTH = 4 * MAX_REF;
  localparam int HIT_W    = $clog2(MAX_HITS + 1);
  localparam int CFG_IW   = 3;

  // item modes
  localparam logic [1:0] MODE_OCC  = 2'd0;
  localparam logic [1:0] MODE_SA   = 2'd1;
  localparam logic [1:0] MODE_SEED = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] REG_COUNT_A    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_COUNT_C    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_COUNT_G    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_COUNT_T    = 3'd3;
  localparam logic [CFG_IW-1:0] REG_REF_LENGTH = 3'd4;

  // result kinds
  localparam logic KIND_INTERVAL = 1'b0;
  localparam logic KIND_HIT      = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic take;       // request accepted this cycle
    logic rd_lo;      // occurrence read at low bound
    logic rd_hi;      // occurrence read at high bound, capture low sum
    logic upd;        // commit new bounds
    logic fin;        // size the hit run
    logic emit_iv;    // load interval result
    logic hit_rd;     // suffix array read
    logic emit_hit;   // load hit result
    logic seed_done;  // arm next seed
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic dead;
    logic last;
    logic n_zero;
    logic hit_last;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/fmbs_ram.sv =====
module fmbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/fmbs_ctrl.sv =====
module fmbs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [1:0]    mode,
  input  fmbs_pkg::stat_t stat,
  output logic          in_ready,
  output fmbs_pkg::cmd_t  cmd
);
  import fmbs_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_LOOK    = 8'b0000_0010,
    S_RDHI    = 8'b0000_0100,
    S_UPD     = 8'b0000_1000,
    S_FIN     = 8'b0001_0000,
    S_EMIT_IV = 8'b0010_0000,
    S_HIT_RD  = 8'b0100_0000,
    S_HIT_OUT = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && mode == MODE_SEED) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        // an empty interval skips the table reads
        if (stat.dead) begin
          state_next = stat.last ? S_FIN : S_IDLE;
        end else begin
          cmd.rd_lo  = 1'b1;
          state_next = S_RDHI;
        end
      end
      S_RDHI: begin
        cmd.rd_hi  = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = stat.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_EMIT_IV;
      end
      S_EMIT_IV: begin
        if (stat.out_free) begin
          cmd.emit_iv = 1'b1;
          if (stat.n_zero) begin
            cmd.seed_done = 1'b1;
            state_next    = S_IDLE;
          end else begin
            state_next = S_HIT_RD;
          end
        end
      end
      S_HIT_RD: begin
        cmd.hit_rd = 1'b1;
        state_next = S_HIT_OUT;
      end
      S_HIT_OUT: begin
        if (stat.out_free) begin
          cmd.emit_hit = 1'b1;
          if (stat.hit_last) begin
            cmd.seed_done = 1'b1;
            state_next    = S_IDLE;
          end else begin
            state_next = S_HIT_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/fmbs_datapath.sv =====
module fmbs_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [fmbs_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [fmbs_pkg::DATA_W-1:0]   cfg_data,
  input  logic [1:0]                    mode,
  input  logic [1:0]                    base,
  input  logic [fmbs_pkg::DATA_W-1:0]   index,
  input  logic [fmbs_pkg::DATA_W-1:0]   value,
  input  logic                          last,
  input  fmbs_pkg::cmd_t                cmd,
  output fmbs_pkg::stat_t               stat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          kind,
  output logic [fmbs_pkg::DATA_W-1:0]   interval_start,
  output logic [fmbs_pkg::DATA_W-1:0]   interval_end,
  output logic [fmbs_pkg::DATA_W-1:0]   position,
  output logic                          truncated,
  output logic                          end_of_run
);
  import fmbs_pkg::*;

  logic [DATA_W-1:0] count [4];
  logic [DATA_W-1:0] ref_len;
  logic [DATA_W-1:0] cur_low;
  logic [DATA_W-1:0] cur_high;
  logic              seed_start;
  logic              dead;
  logic [1:0]        base_q;
  logic              last_q;
  logic [DATA_W-1:0] lo_sum;
  logic [HIT_W-1:0]  n_hits;
  logic [HIT_W-1:0]  hit_idx;
  logic              trunc;

  logic              in_range;
  logic              occ_wr;
  logic              sa_wr;
  logic [OCC_AW-1:0] occ_rd_addr;
  logic [DATA_W-1:0] occ_rd_data;
  logic [REF_AW-1:0] sa_rd_addr;
  logic [DATA_W-1:0] sa_rd_data;
  logic [DATA_W-1:0] hi_sum;
  logic [DATA_W-1:0] span;
  logic              out_free;

  assign in_range = 32'(index) < MAX_REF;
  assign occ_wr   = cmd.take && mode == MODE_OCC && in_range;
  assign sa_wr    = cmd.take && mode == MODE_SA && in_range;

  assign occ_rd_addr = cmd.rd_hi ? {base_q, cur_high[REF_AW-1:0]}
                                 : {base_q, cur_low[REF_AW-1:0]};
  assign sa_rd_addr  = REF_AW'(cur_low + DATA_W'(hit_idx));

  fmbs_ram #(.WIDTH(DATA_W), .DEPTH(OCC_DEPTH)) u_occ_ram (
    .clk     (clk),
    .wr_en   (occ_wr),
    .wr_addr ({base, index[REF_AW-1:0]}),
    .wr_data (value),
    .rd_en   (cmd.rd_lo | cmd.rd_hi),
    .rd_addr (occ_rd_addr),
    .rd_data (occ_rd_data)
  );

  fmbs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_REF)) u_sa_ram (
    .clk     (clk),
    .wr_en   (sa_wr),
    .wr_addr (index[REF_AW-1:0]),
    .wr_data (value),
    .rd_en   (cmd.hit_rd),
    .rd_addr (sa_rd_addr),
    .rd_data (sa_rd_data)
  );

  assign hi_sum = count[base_q] + occ_rd_data;
  assign span   = (cur_low < cur_high) ? cur_high - cur_low : '0;
  assign out_free = !out_valid || !out_stall;

  assign stat.dead     = dead;
  assign stat.last     = last_q;
  assign stat.n_zero   = n_hits == '0;
  assign stat.hit_last = hit_idx + HIT_W'(1) == n_hits;
  assign stat.out_free = out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        count[i] <= '0;
      end
      ref_len <= DATA_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COUNT_A:    count[0] <= cfg_data;
        REG_COUNT_C:    count[1] <= cfg_data;
        REG_COUNT_G:    count[2] <= cfg_data;
        REG_COUNT_T:    count[3] <= cfg_data;
        REG_REF_LENGTH: ref_len  <= cfg_data;
        default: ;
      endcase
    end
  end

  // search state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_low    <= '0;
      cur_high   <= '0;
      seed_start <= 1'b1;
      dead       <= 1'b0;
      last_q     <= 1'b0;
      n_hits     <= '0;
      hit_idx    <= '0;
      trunc      <= 1'b0;
    end else begin
      if (cmd.take && mode == MODE_SEED) begin
        last_q <= last;
        if (seed_start) begin
          cur_low    <= '0;
          cur_high   <= ref_len;
          dead       <= 1'b0;
          seed_start <= 1'b0;
        end
      end
      if (cmd.upd) begin
        cur_low  <= lo_sum;
        cur_high <= hi_sum;
        dead     <= lo_sum >= hi_sum;
      end
      if (cmd.fin) begin
        hit_idx <= '0;
        if (span > DATA_W'(MAX_HITS)) begin
          n_hits <= HIT_W'(MAX_HITS);
          trunc  <= 1'b1;
        end else begin
          n_hits <= span[HIT_W-1:0];
          trunc  <= 1'b0;
        end
      end
      if (cmd.emit_hit) begin
        hit_idx <= hit_idx + HIT_W'(1);
      end
      if (cmd.seed_done) begin
        seed_start <= 1'b1;
        dead       <= 1'b0;
      end
    end
  end

  // payload latches
  always_ff @(posedge clk) begin
    if (cmd.take && mode == MODE_SEED) begin
      base_q <= base;
    end
    if (cmd.rd_hi) begin
      lo_sum <= hi_sum;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_iv || cmd.emit_hit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_iv) begin
      kind           <= KIND_INTERVAL;
      interval_start <= cur_low;
      interval_end   <= cur_high;
      position       <= '0;
      truncated      <= trunc;
      end_of_run     <= n_hits == '0;
    end else if (cmd.emit_hit) begin
      kind           <= KIND_HIT;
      interval_start <= cur_low;
      interval_end   <= cur_high;
      position       <= sa_rd_data;
      truncated      <= trunc;
      end_of_run     <= stat.hit_last;
    end
  end

endmodule

// ===== sv/fm_index_backward_search_top.sv =====
// fm-index exact-match backward search. requests on the input channel either
// load the occurrence table (mode 0, per base and position), load the suffix
// array (mode 1), or carry one seed base (mode 2), last base of the seed
// first; mode 3 is dropped. configuration (base counts and ref_length) is
// written through cfg_write/cfg_index/cfg_data. the user must write it only
// while the block is idle; the block itself does not enforce this. a load is
// written as it is accepted. a live seed base passes through the accept, two
// reads on the one read port of the occurrence ram (low bound, then high
// bound) and a commit of the new bounds; once the interval is empty a base
// only sees the accept and the dead check. after the final base the run is
// sized, the interval result is emitted, and each hit position takes a suffix
// array ram read then an output load, at most MAX_HITS hits; the output side
// can stall each result. results leave through one output register, so the
// block keeps working while a result waits until it needs to load the next
// one. no clearing pass after reset: table entries are undefined until loaded.
module fm_index_backward_search_top (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write port
  input  logic                        cfg_write,
  input  logic [fmbs_pkg::CFG_IW-1:0] cfg_index,
  input  logic [fmbs_pkg::DATA_W-1:0] cfg_data,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  mode,
  input  logic [1:0]                  base,
  input  logic [fmbs_pkg::DATA_W-1:0] index,
  input  logic [fmbs_pkg::DATA_W-1:0] value,
  input  logic                        last,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        kind,
  output logic [fmbs_pkg::DATA_W-1:0] interval_start,
  output logic [fmbs_pkg::DATA_W-1:0] interval_end,
  output logic [fmbs_pkg::DATA_W-1:0] position,
  output logic                        truncated,
  output logic                        end_of_run
);
  import fmbs_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  // requests are taken only while the controller sits idle
  assign in_stall = !in_ready;

  fmbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // tables, bounds, hit counter and the output register
  fmbs_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mode           (mode),
    .base           (base),
    .index          (index),
    .value          (value),
    .last           (last),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .interval_start (interval_start),
    .interval_end   (interval_end),
    .position       (position),
    .truncated      (truncated),
    .end_of_run     (end_of_run)
  );

endmodule

// ===== sv/fmbs_checker.sv =====
module fmbs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        kind,
  input logic [fmbs_pkg::DATA_W-1:0] interval_start,
  input logic [fmbs_pkg::DATA_W-1:0] interval_end,
  input logic [fmbs_pkg::DATA_W-1:0] position,
  input logic                        truncated,
  input logic                        end_of_run
);
  import fmbs_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(position)
      && $stable(interval_start) && $stable(end_of_run))
    else $error("stalled result changed");

  // hits only come from a non-empty interval
  a_hit_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_HIT |-> interval_start < interval_end)
    else $error("hit from empty interval");

  // an empty interval ends its run at once
  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_INTERVAL && !(interval_start < interval_end)
      |-> end_of_run && !truncated)
    else $error("empty interval not closed");

  // truncation only past the hit cap
  a_trunc: assert property (@(posedge clk) disable iff (rst)
    out_valid && truncated
      |-> interval_start < interval_end
        && (interval_end - interval_start) > DATA_W'(MAX_HITS))
    else $error("truncated without overflow");

  // interval results carry no position
  a_iv_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_INTERVAL |-> position == '0)
    else $error("interval result with position");

endmodule

bind fm_index_backward_search_top fmbs_checker u_fmbs_checker (.*);
